### sv/gbt_pkg.sv
`default_nettype none

package gbt_pkg;

  localparam int MAX_VERTICES = 32;
  localparam int MAX_DEGREE   = 8;

  // Vertex numbers, counts and pointers (counts reach MAX_VERTICES itself)
  localparam int VTX_W = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  // Degree and neighbour index (degree reaches MAX_DEGREE itself)
  localparam int DEG_W = $clog2(MAX_DEGREE + 1);

  localparam int NBR_DEPTH = MAX_VERTICES * MAX_DEGREE;
  localparam int NBR_AW    = $clog2(NBR_DEPTH);

  // Frontier entry: {next neighbour index, vertex}
  localparam int FR_AW = $clog2(MAX_VERTICES);
  localparam int FR_W  = DEG_W + VTX_W;

  // Configuration port
  localparam int CFG_W  = 6;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic [CFG_W-1:0] VCOUNT_RESET = CFG_W'(MAX_VERTICES);

  localparam logic [DEG_W:0] DEG_LIMIT = (DEG_W + 1)'(MAX_DEGREE);

  typedef enum logic [1:0] {
    REQ_ADD  = 2'd0,
    REQ_BFS  = 2'd1,
    REQ_DFS  = 2'd2,
    REQ_NONE = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    REG_VERTEX_COUNT = 1'b0
  } reg_e;

  // Result command from the walker to the output stage
  typedef struct packed {
    logic             push;
    logic             close;
    logic             last;
    logic [VTX_W-1:0] vertex;
    status_e          status;
  } res_cmd_t;

  function automatic logic [NBR_AW-1:0] nbr_addr(input logic [VTX_W-1:0] u,
                                                 input logic [DEG_W-1:0] idx);
    return NBR_AW'(u * MAX_DEGREE + idx);
  endfunction

endpackage

`default_nettype wire

### sv/gbt_ram.sv
`default_nettype none

module gbt_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

### sv/gbt_ostage.sv
`default_nettype none

module gbt_ostage (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire gbt_pkg::res_cmd_t         cmd_i,
  output      logic                      ready_o,
  output      logic                      out_valid_o,
  input  wire logic                      out_stall_i,
  output      logic [gbt_pkg::VTX_W-1:0] vertex_o,
  output      logic                      last_o,
  output      logic [1:0]                status_o
);

  import gbt_pkg::*;

  logic             hold_v_q, hold_v_d;
  logic             hold_last_q, hold_last_d;
  logic [VTX_W-1:0] hold_vtx_q;
  status_e          hold_st_q;
  logic             out_v_q, out_v_d;
  logic [VTX_W-1:0] out_vtx_q;
  logic             out_last_q;
  status_e          out_st_q;

  logic out_space;
  logic push;
  logic close;
  logic move;

  // One result waits in the hold slot until the next one, or the end of the
  // request, tells whether it is the last.
  assign out_space = !out_v_q || !out_stall_i;
  assign ready_o   = !hold_v_q || out_space;
  assign push      = cmd_i.push && ready_o;
  assign close     = cmd_i.close && ready_o;
  assign move      = hold_v_q && out_space && (hold_last_q || push || close);

  always_comb begin
    out_v_d     = move ? 1'b1 : (out_v_q && out_stall_i);
    hold_v_d    = push ? 1'b1 : (move ? 1'b0 : hold_v_q);
    hold_last_d = push ? cmd_i.last : (close ? 1'b1 : hold_last_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q    <= 1'b0;
      hold_last_q <= 1'b0;
      out_v_q     <= 1'b0;
    end else begin
      hold_v_q    <= hold_v_d;
      hold_last_q <= hold_last_d;
      out_v_q     <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      hold_vtx_q <= cmd_i.vertex;
      hold_st_q  <= cmd_i.status;
    end
    if (move) begin
      out_vtx_q  <= hold_vtx_q;
      out_st_q   <= hold_st_q;
      out_last_q <= hold_last_q || close;
    end
  end

  assign out_valid_o = out_v_q;
  assign vertex_o    = out_vtx_q;
  assign last_o      = out_last_q;
  assign status_o    = out_st_q;

endmodule

`default_nettype wire

### sv/gbt_walker.sv
`default_nettype none

module gbt_walker (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      req_valid_i,
  output      logic                      req_stall_o,
  input  wire gbt_pkg::req_e             req_type_i,
  input  wire logic [gbt_pkg::VTX_W-1:0] first_vertex_i,
  input  wire logic [gbt_pkg::VTX_W-1:0] second_vertex_i,
  input  wire logic [gbt_pkg::CNT_W-1:0] eff_n_i,
  output      gbt_pkg::res_cmd_t         cmd_o,
  input  wire logic                      cmd_ready_i
);

  import gbt_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ADD_RDA,
    S_ADD_RDB,
    S_ADD_WB,
    S_ADD_DONE,
    S_BFS_POP,
    S_BFS_U,
    S_BFS_DEG,
    S_BFS_EMIT,
    S_BFS_CHK,
    S_DFS_PUSH,
    S_DFS_TOP,
    S_DFS_ENT,
    S_DFS_DEG,
    S_DFS_CHK,
    S_FIN
  } state_e;

  state_e                  state_q, state_d;
  logic [VTX_W-1:0]        a_q, a_d;
  logic [VTX_W-1:0]        b_q, b_d;
  logic [DEG_W-1:0]        da_q, da_d;
  logic [DEG_W-1:0]        db_q, db_d;
  status_e                 st_q, st_d;
  logic [VTX_W-1:0]        u_q, u_d;
  logic [DEG_W-1:0]        idx_q, idx_d;
  logic [DEG_W-1:0]        d_q, d_d;
  logic [CNT_W-1:0]        head_q, head_d;
  logic [CNT_W-1:0]        tail_q, tail_d;
  logic [MAX_VERTICES-1:0] visited_q, visited_d;
  logic [MAX_VERTICES-1:0] deg_vld_q, deg_vld_d;
  logic                    deg_rv_q;

  // Memory ports
  logic              deg_we;
  logic [VTX_W-1:0]  deg_waddr;
  logic [DEG_W-1:0]  deg_wdata;
  logic [VTX_W-1:0]  deg_raddr;
  logic [DEG_W-1:0]  deg_rdata;
  logic [DEG_W-1:0]  deg_rd;
  logic              nbr_we;
  logic [NBR_AW-1:0] nbr_waddr;
  logic [VTX_W-1:0]  nbr_wdata;
  logic [NBR_AW-1:0] nbr_raddr;
  logic [VTX_W-1:0]  nbr_rdata;
  logic              fr_we;
  logic [FR_AW-1:0]  fr_waddr;
  logic [FR_W-1:0]   fr_wdata;
  logic [FR_AW-1:0]  fr_raddr;
  logic [FR_W-1:0]   fr_rdata;

  logic             take_w;
  logic             full;
  logic [DEG_W-1:0] dfs_deg;
  logic [CNT_W-1:0] top_idx;

  gbt_ram #(.DEPTH(MAX_VERTICES), .WIDTH(DEG_W)) u_deg_ram (
    .clk_i   (clk_i),
    .we_i    (deg_we),
    .waddr_i (deg_waddr),
    .wdata_i (deg_wdata),
    .raddr_i (deg_raddr),
    .rdata_o (deg_rdata)
  );

  gbt_ram #(.DEPTH(NBR_DEPTH), .WIDTH(VTX_W)) u_nbr_ram (
    .clk_i   (clk_i),
    .we_i    (nbr_we),
    .waddr_i (nbr_waddr),
    .wdata_i (nbr_wdata),
    .raddr_i (nbr_raddr),
    .rdata_o (nbr_rdata)
  );

  gbt_ram #(.DEPTH(MAX_VERTICES), .WIDTH(FR_W)) u_fr_ram (
    .clk_i   (clk_i),
    .we_i    (fr_we),
    .waddr_i (fr_waddr),
    .wdata_i (fr_wdata),
    .raddr_i (fr_raddr),
    .rdata_o (fr_rdata)
  );

  // A degree entry never written reads as zero
  assign deg_rd = deg_rv_q ? deg_rdata : '0;

  // Neighbour just read is new, in range, and the frontier has room
  assign take_w = (CNT_W'(nbr_rdata) < eff_n_i) && !visited_q[nbr_rdata] &&
                  (tail_q < CNT_W'(MAX_VERTICES));

  assign full = (a_q == b_q) ? ((DEG_W + 1)'(da_q) + (DEG_W + 1)'(2) > DEG_LIMIT)
                             : (((DEG_W + 1)'(da_q) >= DEG_LIMIT) ||
                                ((DEG_W + 1)'(deg_rd) >= DEG_LIMIT));

  assign dfs_deg = (state_q == S_DFS_DEG) ? deg_rd : d_q;
  assign top_idx = tail_q - CNT_W'(1);

  assign req_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d   = state_q;
    a_d       = a_q;
    b_d       = b_q;
    da_d      = da_q;
    db_d      = db_q;
    st_d      = st_q;
    u_d       = u_q;
    idx_d     = idx_q;
    d_d       = d_q;
    head_d    = head_q;
    tail_d    = tail_q;
    visited_d = visited_q;
    deg_vld_d = deg_vld_q;

    deg_we    = 1'b0;
    deg_waddr = a_q;
    deg_wdata = '0;
    deg_raddr = a_q;
    nbr_we    = 1'b0;
    nbr_waddr = '0;
    nbr_wdata = '0;
    nbr_raddr = '0;
    fr_we     = 1'b0;
    fr_waddr  = '0;
    fr_wdata  = '0;
    fr_raddr  = '0;
    cmd_o     = '0;

    case (state_q)
      S_IDLE: begin
        deg_raddr = first_vertex_i;
        if (req_valid_i) begin
          a_d  = first_vertex_i;
          b_d  = second_vertex_i;
          st_d = ST_OK;
          u_d  = '0;
          case (req_type_i)
            REQ_ADD: begin
              if ((CNT_W'(first_vertex_i) >= eff_n_i) ||
                  (CNT_W'(second_vertex_i) >= eff_n_i)) begin
                st_d    = ST_RANGE;
                state_d = S_ADD_DONE;
              end else begin
                state_d = S_ADD_RDA;
              end
            end
            REQ_BFS, REQ_DFS: begin
              // Seed the frontier with vertex 0 and mark it visited
              visited_d    = '0;
              visited_d[0] = 1'b1;
              fr_we        = 1'b1;
              head_d       = '0;
              tail_d       = CNT_W'(1);
              state_d      = (req_type_i == REQ_BFS) ? S_BFS_POP : S_DFS_PUSH;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_ADD_RDA: begin
        da_d      = deg_rd;
        deg_raddr = b_q;
        state_d   = S_ADD_RDB;
      end

      S_ADD_RDB: begin
        if (full) begin
          st_d    = ST_FULL;
          state_d = S_ADD_DONE;
        end else begin
          nbr_we    = 1'b1;
          nbr_waddr = nbr_addr(a_q, da_q);
          nbr_wdata = b_q;
          deg_we    = 1'b1;
          deg_waddr = a_q;
          deg_wdata = da_q + DEG_W'(1);
          deg_vld_d[a_q] = 1'b1;
          // A self-loop takes the slot right after the first one
          db_d    = (a_q == b_q) ? (da_q + DEG_W'(1)) : deg_rd;
          state_d = S_ADD_WB;
        end
      end

      S_ADD_WB: begin
        nbr_we    = 1'b1;
        nbr_waddr = nbr_addr(b_q, db_q);
        nbr_wdata = a_q;
        deg_we    = 1'b1;
        deg_waddr = b_q;
        deg_wdata = db_q + DEG_W'(1);
        deg_vld_d[b_q] = 1'b1;
        state_d   = S_ADD_DONE;
      end

      S_ADD_DONE: begin
        cmd_o.push   = 1'b1;
        cmd_o.last   = 1'b1;
        cmd_o.status = st_q;
        if (cmd_ready_i) begin
          state_d = S_IDLE;
        end
      end

      S_BFS_POP: begin
        if (head_q < tail_q) begin
          fr_raddr = head_q[FR_AW-1:0];
          head_d   = head_q + CNT_W'(1);
          state_d  = S_BFS_U;
        end else begin
          state_d = S_FIN;
        end
      end

      S_BFS_U: begin
        u_d       = fr_rdata[VTX_W-1:0];
        deg_raddr = fr_rdata[VTX_W-1:0];
        state_d   = S_BFS_DEG;
      end

      S_BFS_DEG: begin
        d_d     = deg_rd;
        idx_d   = '0;
        state_d = S_BFS_EMIT;
      end

      S_BFS_EMIT: begin
        cmd_o.push   = 1'b1;
        cmd_o.vertex = u_q;
        if (cmd_ready_i) begin
          if (idx_q < d_q) begin
            nbr_raddr = nbr_addr(u_q, idx_q);
            idx_d     = idx_q + DEG_W'(1);
            state_d   = S_BFS_CHK;
          end else begin
            state_d = S_BFS_POP;
          end
        end
      end

      S_BFS_CHK: begin
        if (take_w) begin
          visited_d[nbr_rdata] = 1'b1;
          fr_we    = 1'b1;
          fr_waddr = tail_q[FR_AW-1:0];
          fr_wdata = FR_W'(nbr_rdata);
          tail_d   = tail_q + CNT_W'(1);
        end
        // Issue the next neighbour read while this one is checked
        if (idx_q < d_q) begin
          nbr_raddr = nbr_addr(u_q, idx_q);
          idx_d     = idx_q + DEG_W'(1);
        end else begin
          state_d = S_BFS_POP;
        end
      end

      S_DFS_PUSH: begin
        cmd_o.push   = 1'b1;
        cmd_o.vertex = u_q;
        if (cmd_ready_i) begin
          state_d = S_DFS_TOP;
        end
      end

      S_DFS_TOP: begin
        if (tail_q != '0) begin
          fr_raddr = top_idx[FR_AW-1:0];
          state_d  = S_DFS_ENT;
        end else begin
          state_d = S_FIN;
        end
      end

      S_DFS_ENT: begin
        u_d       = fr_rdata[VTX_W-1:0];
        idx_d     = fr_rdata[FR_W-1:VTX_W];
        deg_raddr = fr_rdata[VTX_W-1:0];
        state_d   = S_DFS_DEG;
      end

      S_DFS_DEG, S_DFS_CHK: begin
        if (state_q == S_DFS_DEG) begin
          d_d = deg_rd;
        end
        if ((state_q == S_DFS_CHK) && take_w) begin
          // Descend: mark, stack and report the new vertex
          visited_d[nbr_rdata] = 1'b1;
          fr_we    = 1'b1;
          fr_waddr = tail_q[FR_AW-1:0];
          fr_wdata = FR_W'(nbr_rdata);
          tail_d   = tail_q + CNT_W'(1);
          u_d      = nbr_rdata;
          state_d  = S_DFS_PUSH;
        end else if (idx_q < dfs_deg) begin
          // Read the next neighbour and save the resume point on the stack
          nbr_raddr = nbr_addr(u_q, idx_q);
          fr_we     = 1'b1;
          fr_waddr  = top_idx[FR_AW-1:0];
          fr_wdata  = {idx_q + DEG_W'(1), u_q};
          idx_d     = idx_q + DEG_W'(1);
          state_d   = S_DFS_CHK;
        end else begin
          tail_d  = top_idx;
          state_d = S_DFS_TOP;
        end
      end

      S_FIN: begin
        cmd_o.close = 1'b1;
        if (cmd_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      a_q       <= '0;
      b_q       <= '0;
      da_q      <= '0;
      db_q      <= '0;
      st_q      <= ST_OK;
      u_q       <= '0;
      idx_q     <= '0;
      d_q       <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      visited_q <= '0;
      deg_vld_q <= '0;
      deg_rv_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      a_q       <= a_d;
      b_q       <= b_d;
      da_q      <= da_d;
      db_q      <= db_d;
      st_q      <= st_d;
      u_q       <= u_d;
      idx_q     <= idx_d;
      d_q       <= d_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      visited_q <= visited_d;
      deg_vld_q <= deg_vld_d;
      deg_rv_q  <= deg_vld_q[deg_raddr];
    end
  end

endmodule

`default_nettype wire

### sv/graph_bfs_dfs_traversal.sv
// Undirected graph store with breadth-first and depth-first walks.
//
// Input channel (in_valid_i / in_stall_o): one request per transfer. An
// add-edge request appends each endpoint to the other's neighbour list and
// answers with one result carrying a status (ok, list full, out of range).
// A traversal request walks from vertex 0 and returns one result per reached
// vertex in visit order; last_o marks the final result of a request.
// Output channel (out_valid_o / out_stall_i): results, held while stalled.
// Configuration: APB-style register vertex_count at byte address 0; the user
// must write it only while idle (not enforced); values outside 1..32 are clamped.
//
// One request is in flight at a time; in_stall_o stays high until its work
// is done. The single read port of the degree and frontier memories paces
// both the breadth-first and the depth-first walk.
// Reset empties the graph, clears the degree counts and sets vertex_count
// to 32; no clearing pass is needed. A stalled receiver holds the result in
// the output register while one more waits in the hold slot, then the walk
// pauses.

`default_nettype none

module graph_bfs_dfs_traversal (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // request channel
  input  wire logic                       in_valid_i,
  output      logic                       in_stall_o,
  input  wire logic [1:0]                 req_type_i,
  input  wire logic [4:0]                 first_vertex_i,
  input  wire logic [4:0]                 second_vertex_i,
  // result channel
  output      logic                       out_valid_o,
  input  wire logic                       out_stall_i,
  output      logic [4:0]                 vertex_o,
  output      logic                       last_o,
  output      logic [1:0]                 status_o,
  // configuration port
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [gbt_pkg::APB_AW-1:0] paddr,
  input  wire logic [gbt_pkg::APB_DW-1:0] pwdata,
  output      logic [gbt_pkg::APB_DW-1:0] prdata,
  output      logic                       pready
);

  import gbt_pkg::*;

  logic [CFG_W-1:0] vcount_q;
  logic [CNT_W-1:0] eff_n;
  logic             cfg_wr;
  reg_e             reg_sel;
  res_cmd_t         cmd;
  logic             cmd_ready;

  // Register file: word index sits above the byte lane bits
  assign reg_sel = reg_e'(paddr[APB_AW-1:2]);
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && (reg_sel == REG_VERTEX_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= VCOUNT_RESET;
    end else if (cfg_wr) begin
      vcount_q <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    case (reg_sel)
      REG_VERTEX_COUNT: prdata = APB_DW'(vcount_q);
      default:          prdata = '0;
    endcase
  end

  // Clamp the vertex count into 1..MAX_VERTICES
  always_comb begin
    if (vcount_q == '0) begin
      eff_n = CNT_W'(1);
    end else if (32'(vcount_q) > MAX_VERTICES) begin
      eff_n = CNT_W'(MAX_VERTICES);
    end else begin
      eff_n = CNT_W'(vcount_q);
    end
  end

  // Sequencer around the degree, neighbour and frontier memories
  gbt_walker u_walker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_valid_i     (in_valid_i),
    .req_stall_o     (in_stall_o),
    .req_type_i      (req_e'(req_type_i)),
    .first_vertex_i  (first_vertex_i),
    .second_vertex_i (second_vertex_i),
    .eff_n_i         (eff_n),
    .cmd_o           (cmd),
    .cmd_ready_i     (cmd_ready)
  );

  // Hold slot resolves the last flag; output register decouples the receiver
  gbt_ostage u_ostage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .ready_o     (cmd_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .vertex_o    (vertex_o),
    .last_o      (last_o),
    .status_o    (status_o)
  );

endmodule

`default_nettype wire

### sv/gbt_checker.sv
`default_nettype none

module gbt_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic [1:0] req_type_i,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [4:0] vertex_o,
  input wire logic       last_o,
  input wire logic [1:0] status_o
);

  import gbt_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(vertex_o) && $stable(last_o) && $stable(status_o))
    else $error("stalled result changed");

  // An error status only comes in the single add-edge result
  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> last_o && (vertex_o == '0))
    else $error("error status on a non-final or nonzero result");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_OK) || (status_o == ST_FULL) ||
                    (status_o == ST_RANGE))
    else $error("undefined status code");

  // Every real request that is taken raises in_stall_o
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (req_type_i != REQ_NONE) |=> in_stall_o)
    else $error("request taken without going busy");

endmodule

bind graph_bfs_dfs_traversal gbt_checker u_gbt_checker (.*);

`default_nettype wire
